// ===== rtl/srpt_pkg.sv =====
// Shared types and constants for the strongest reader presence table.
`timescale 1ns / 1ps
package srpt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic signed [9:0] STRENGTH_SENTINEL = -10'sd500;

  localparam logic [7:0]  RST_THRESHOLD = 8'hC4;  // -60 dBm
  localparam logic [15:0] RST_EXPIRY    = 16'd21;
  localparam logic [7:0]  RST_ABSENT    = 8'd0;

  localparam logic ACT_REPORT = 1'b0;
  localparam logic ACT_SWEEP  = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_EXPIRY    = 2'd1;
  localparam logic [1:0] CFG_ABSENT    = 2'd2;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_KEPT     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_BELOW    = 3'd3,
    ST_INVALID  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef struct packed {
    logic               action;
    logic [15:0]        tag_id;
    logic [7:0]         floor_code;
    logic signed [7:0]  signal_strength;
    logic               tag_registered;
    logic [31:0]        timestamp;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [15:0] entry_tag_out;
    logic [7:0]  entry_floor_out;
    logic        last;
  } out_word_t;

  // Word handed from cell to cell.
  typedef struct packed {
    logic               active;
    logic               op;
    logic               done;
    status_t            status;
    logic [15:0]        tag;
    logic [7:0]         floor_code;
    logic signed [7:0]  rssi;
    logic [31:0]        stamp;
    logic [CNT_W-1:0]   count;
  } link_t;

  typedef struct packed {
    logic [15:0] expiry;
    logic [7:0]  absent_floor;
  } cell_cfg_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] tag;
    logic [7:0]  floor_code;
    logic        last;
  } emit_t;

endpackage

// ===== rtl/srpt_cell.sv =====
// One table slot of the presence chain; processes the word passing through.
`timescale 1ns / 1ps
module srpt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  srpt_pkg::cell_cfg_t cfg,
  input  srpt_pkg::link_t    link_i,
  input  logic               next_valid_i,
  output srpt_pkg::link_t    link_o,
  output logic               valid_o,
  output srpt_pkg::emit_t    emit_o
);

  localparam logic [srpt_pkg::CNT_W-1:0] MAX_CNT =
    srpt_pkg::CNT_W'(srpt_pkg::MAX_RESULTS);

  logic               valid_r, valid_nxt;
  logic [15:0]        tag_r, tag_nxt;
  logic [7:0]         floor_r, floor_nxt;
  logic signed [9:0]  strength_r, strength_nxt;
  logic [31:0]        seen_r, seen_nxt;
  srpt_pkg::link_t    link_r, link_nxt;
  logic signed [9:0]  rssi_ext;
  logic [31:0]        age;
  logic [7:0]         swept_floor;

  assign rssi_ext    = {{2{link_i.rssi[7]}}, link_i.rssi};
  assign age         = link_i.stamp - seen_r;
  assign swept_floor = (age > {16'd0, cfg.expiry}) ? cfg.absent_floor : floor_r;

  always_comb begin
    valid_nxt    = valid_r;
    tag_nxt      = tag_r;
    floor_nxt    = floor_r;
    strength_nxt = strength_r;
    seen_nxt     = seen_r;
    link_nxt     = link_i;
    emit_o       = '0;
    if (link_i.active && link_i.op == srpt_pkg::ACT_REPORT && !link_i.done) begin
      if (valid_r && tag_r == link_i.tag) begin
        link_nxt.done = 1'b1;
        if (strength_r <= rssi_ext) begin
          floor_nxt       = link_i.floor_code;
          strength_nxt    = rssi_ext;
          seen_nxt        = link_i.stamp;
          link_nxt.status = srpt_pkg::ST_UPDATED;
        end else begin
          link_nxt.status = srpt_pkg::ST_KEPT;
        end
      end else if (!valid_r) begin
        valid_nxt       = 1'b1;
        tag_nxt         = link_i.tag;
        floor_nxt       = link_i.floor_code;
        strength_nxt    = rssi_ext;
        seen_nxt        = link_i.stamp;
        link_nxt.done   = 1'b1;
        link_nxt.status = srpt_pkg::ST_INSERTED;
      end
    end else if (link_i.active && link_i.op == srpt_pkg::ACT_SWEEP && valid_r) begin
      floor_nxt    = swept_floor;
      strength_nxt = srpt_pkg::STRENGTH_SENTINEL;
      if (link_i.count < MAX_CNT) begin
        emit_o.valid      = 1'b1;
        emit_o.tag        = tag_r;
        emit_o.floor_code = swept_floor;
        emit_o.last       = !next_valid_i || (link_i.count == MAX_CNT - 1'b1);
        link_nxt.count    = link_i.count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      link_r  <= '0;
    end else if (adv) begin
      valid_r <= valid_nxt;
      link_r  <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r      <= tag_nxt;
      floor_r    <= floor_nxt;
      strength_r <= strength_nxt;
      seen_r     <= seen_nxt;
    end
  end

  assign link_o  = link_r;
  assign valid_o = valid_r;

endmodule

// ===== rtl/strongest_reader_presence_table_top.sv =====
// Top level of the strongest reader presence table: intake, cell chain, output register.
`timescale 1ns / 1ps
// Path: a status word passes the head, every cell link and the output register;
//   swept entry i (from 0) passes the head, cell links 0 to i-1 and the output register.
// Items: one at a time, the intake stalls until the item word leaves the chain;
//   output stalls freeze the chain.
// Reset: synchronous, active low; slot valid bits clear at once, no clearing pass,
//   and the registers return to threshold -60, expiry 21, absent floor 0.
module strongest_reader_presence_table_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srpt_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output srpt_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int N = srpt_pkg::TABLE_ENTRIES;

  // configuration registers
  logic signed [7:0] thr_r;
  logic [15:0]       expiry_r;
  logic [7:0]        absent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= srpt_pkg::RST_THRESHOLD;
      expiry_r <= srpt_pkg::RST_EXPIRY;
      absent_r <= srpt_pkg::RST_ABSENT;
    end else if (cfg_we) begin
      case (cfg_index)
        srpt_pkg::CFG_THRESHOLD: thr_r    <= cfg_data[7:0];
        srpt_pkg::CFG_EXPIRY:    expiry_r <= cfg_data;
        srpt_pkg::CFG_ABSENT:    absent_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  srpt_pkg::cell_cfg_t cell_cfg;
  assign cell_cfg.expiry       = expiry_r;
  assign cell_cfg.absent_floor = absent_r;

  // handshake and chain control
  logic busy_r;
  logic out_valid_r;
  srpt_pkg::out_word_t out_word_r;
  logic adv;
  logic accept;

  assign adv      = !out_valid_r || !out_stall;   // output register can take a word
  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;

  // intake: precheck of threshold and validity, then into the chain head
  srpt_pkg::link_t head_r, head_nxt;

  always_comb begin
    head_nxt            = '0;
    head_nxt.active     = 1'b1;
    head_nxt.op         = in_word.action;
    head_nxt.tag        = in_word.tag_id;
    head_nxt.floor_code = in_word.floor_code;
    head_nxt.rssi       = in_word.signal_strength;
    head_nxt.stamp      = in_word.timestamp;
    head_nxt.status     = srpt_pkg::ST_FULL;   // stands if no slot takes the report
    if (in_word.signal_strength < thr_r) begin
      head_nxt.done   = 1'b1;
      head_nxt.status = srpt_pkg::ST_BELOW;
    end else if (in_word.signal_strength == 8'sd0 || !in_word.tag_registered) begin
      head_nxt.done   = 1'b1;
      head_nxt.status = srpt_pkg::ST_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else if (accept) begin
      head_r <= head_nxt;
    end else if (adv) begin
      head_r.active <= 1'b0;
    end
  end

  // cell chain
  srpt_pkg::link_t links [N+1];
  logic            valids [N+1];
  srpt_pkg::emit_t emits [N];

  assign links[0]  = head_r;
  assign valids[N] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    srpt_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .adv          (adv),
      .cfg          (cell_cfg),
      .link_i       (links[i]),
      .next_valid_i (valids[i+1]),
      .link_o       (links[i+1]),
      .valid_o      (valids[i]),
      .emit_o       (emits[i])
    );
  end

  srpt_pkg::link_t tail;
  assign tail = links[N];

  // collect the swept entry of the cell holding the sweep word
  srpt_pkg::emit_t emit_any;
  always_comb begin
    emit_any = '0;
    for (int i = 0; i < N; i++) begin
      emit_any = emit_any | emits[i];
    end
  end

  logic tail_report;
  assign tail_report = tail.active && tail.op == srpt_pkg::ACT_REPORT;

  srpt_pkg::out_word_t word_nxt;
  always_comb begin
    word_nxt = '0;
    if (tail_report) begin
      word_nxt.kind   = srpt_pkg::KIND_STATUS;
      word_nxt.status = tail.status;
      word_nxt.last   = 1'b1;
    end else begin
      word_nxt.kind            = srpt_pkg::KIND_ENTRY;
      word_nxt.status          = srpt_pkg::ST_UPDATED;
      word_nxt.entry_tag_out   = emit_any.tag;
      word_nxt.entry_floor_out = emit_any.floor_code;
      word_nxt.last            = emit_any.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (adv && tail.active) begin
        busy_r <= 1'b0;   // item word leaves the chain
      end
      if (adv) begin
        out_valid_r <= tail_report || emit_any.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  logic [N:0] src_vec;
  always_comb begin
    for (int i = 0; i < N; i++) begin
      src_vec[i] = emits[i].valid;
    end
    src_vec[N] = tail_report;
  end

  // only one place drives the output register in a cycle
  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(src_vec)) else $error("two result sources at once");

  // a word in the chain means the intake is closed
  a_busy_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (tail.active || head_r.active) |-> busy_r) else $error("chain word while idle");

  // a status word always ends its item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.kind == srpt_pkg::KIND_STATUS) |-> out_word_r.last)
    else $error("status word without last");

  // the chain freezes while the output is blocked
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(tail)) else $error("chain moved under stall");
`endif

endmodule
